>>> design/fhr_pkg.sv
// ----------------------------------------------------------------------------
// fhr_pkg: shared types and constants for the five level hysteresis regulator
// Field widths, drive level codes and configuration register indexes.
// ----------------------------------------------------------------------------
package fhr_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned BandW   = 16;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned ErrW    = SampleW + 1;
  localparam int unsigned CmpW    = ErrW + 1;
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic        [BandW-1:0]   band_t;
  typedef logic signed [LevelW-1:0]  level_t;
  typedef logic signed [ErrW-1:0]    err_t;
  typedef logic signed [CmpW-1:0]    cmp_t;

  localparam level_t LvlNeg2 = -3'sd2;
  localparam level_t LvlNeg1 = -3'sd1;
  localparam level_t LvlZero = 3'sd0;
  localparam level_t LvlPos1 = 3'sd1;
  localparam level_t LvlPos2 = 3'sd2;

  localparam logic [1:0] RegInner = 2'd0;
  localparam logic [1:0] RegLow   = 2'd1;
  localparam logic [1:0] RegMid   = 2'd2;
  localparam logic [1:0] RegHigh  = 2'd3;

endpackage

>>> design/fhr_in_if.sv
// ----------------------------------------------------------------------------
// fhr_in_if: input sample channel
// Valid/ready channel carrying one setpoint and measurement pair per beat.
// ----------------------------------------------------------------------------
interface fhr_in_if
  import fhr_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t setpoint;
  sample_t measurement;

  modport source (output valid, output setpoint, output measurement, input ready);
  modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

>>> design/fhr_out_if.sv
// ----------------------------------------------------------------------------
// fhr_out_if: drive level result channel
// Valid/ready channel carrying one drive level and band status per beat.
// ----------------------------------------------------------------------------
interface fhr_out_if
  import fhr_pkg::*;
;
  logic   valid;
  logic   ready;
  level_t drive_level;
  logic   bands_valid;

  modport source (output valid, output drive_level, output bands_valid, input ready);
  modport sink   (input valid, input drive_level, input bands_valid, output ready);
endinterface

>>> design/five_level_hysteresis_regulator.sv
// ----------------------------------------------------------------------------
// five_level_hysteresis_regulator: five level relay with hysteresis
// Error = setpoint - measurement drives a -2..+2 level through band rules.
// ----------------------------------------------------------------------------
// One sample is accepted per cycle while the error stage is free or passes its
// beat on. Its result beat goes from the error register to the result register
// and is offered from there; a stalled result side holds it in either. The
// first stage registers the 17-bit error. The second compares it with the four
// bands and the stored level, and writes both the level register and the
// result register. The level register feeds straight back into the band rules,
// so throughput is one beat per clock whenever the result side takes its beats.
// The bands are checked (high > mid > low > inner) for every sample; while they
// fail, the stored level is held and returned with bands_valid low. Write the
// bands over the APB port only while no sample is in flight.
module five_level_hysteresis_regulator
  import fhr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  fhr_in_if.sink           in_ch,
  fhr_out_if.source        out_ch
);

  band_t inner_q, low_q, mid_q, high_q;

  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= '0;
      low_q   <= '0;
      mid_q   <= '0;
      high_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegInner: inner_q <= pwdata[BandW-1:0];
        RegLow:   low_q   <= pwdata[BandW-1:0];
        RegMid:   mid_q   <= pwdata[BandW-1:0];
        RegHigh:  high_q  <= pwdata[BandW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegInner: prdata = {{(DataW-BandW){1'b0}}, inner_q};
      RegLow:   prdata = {{(DataW-BandW){1'b0}}, low_q};
      RegMid:   prdata = {{(DataW-BandW){1'b0}}, mid_q};
      RegHigh:  prdata = {{(DataW-BandW){1'b0}}, high_q};
      default:  prdata = '0;
    endcase
  end

  // stage one: error register
  logic s1_valid_q;
  err_t err_q;
  logic s1_adv;
  logic out_load;

  assign out_load     = s1_valid_q && (!out_ch.valid || out_ch.ready);
  assign s1_adv       = out_load;
  assign in_ch.ready  = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      err_q <= ErrW'(in_ch.setpoint) - ErrW'(in_ch.measurement);
    end
  end

  // stage two: band rules
  cmp_t   e, a, b, c, d, na, nb, nc, nd;
  logic   bands_ok;
  level_t level_q, level_d, rule_lvl;
  logic   y_p2, y_p1, y_z, y_n1, y_n2;

  assign e  = CmpW'(err_q);
  assign a  = cmp_t'({2'b00, inner_q});
  assign b  = cmp_t'({2'b00, low_q});
  assign c  = cmp_t'({2'b00, mid_q});
  assign d  = cmp_t'({2'b00, high_q});
  assign na = -a;
  assign nb = -b;
  assign nc = -c;
  assign nd = -d;

  assign bands_ok = (high_q > mid_q) && (mid_q > low_q) && (low_q > inner_q);

  assign y_p2 = (level_q == LvlPos2);
  assign y_p1 = (level_q == LvlPos1);
  assign y_z  = (level_q == LvlZero);
  assign y_n1 = (level_q == LvlNeg1);
  assign y_n2 = (level_q == LvlNeg2);

  always_comb begin
    if (e >= d || (e >= c && e < d && (y_p2 || y_z))) begin
      rule_lvl = LvlPos2;
    end else if ((e >= b && e < c) || (e >= c && e < d && y_p1) ||
                 (e > a && e <= b && y_p1)) begin
      rule_lvl = LvlPos1;
    end else if ((e > na && e < a) || (e > a && e < b && y_z) ||
                 (e < na && e > nb && y_z)) begin
      rule_lvl = LvlZero;
    end else if ((e <= nb && e > nc) || (e <= nc && e > nd && y_n1) ||
                 (e < na && e >= nb && y_n1)) begin
      rule_lvl = LvlNeg1;
    end else if (e <= nd || (e <= nc && e > nd && (y_n2 || y_z))) begin
      rule_lvl = LvlNeg2;
    end else begin
      rule_lvl = LvlZero;
    end
    level_d = bands_ok ? rule_lvl : level_q;
  end

  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= LvlZero;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        level_q <= level_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  level_t drive_q;
  logic   bv_q;

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      drive_q <= level_d;
      bv_q    <= bands_ok;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.drive_level = drive_q;
  assign out_ch.bands_valid = bv_q;

  a_lvl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (drive_q != 3'sd3 && drive_q != -3'sd3 && drive_q != -3'sd4))
    else $error("drive level out of range");

  a_lvl_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (drive_q == level_q))
    else $error("result level differs from stored level");

  a_hold_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !bands_ok) |=> (level_q == $past(level_q)))
    else $error("level changed with invalid bands");

  a_s1_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(err_q)))
    else $error("stalled error stage lost its beat");

endmodule
